[hdl/xenc_pkg.sv]
// ----------------------------------------------------------------------------
// x86-64 encoder package
// Shared constants, form codes and the instruction descriptor type that
// travels from the front end through the queue to the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package xenc_pkg;

	localparam int OFFSET_WIDTH = 32;
	localparam int MAX_BYTES    = 10;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] REX_W      = 8'h48;
	localparam logic [7:0] REX_B_ONLY = 8'h41;
	localparam logic [7:0] OPC_MOV_ST = 8'h89;
	localparam logic [7:0] OPC_MOV_LD = 8'h8B;
	localparam logic [7:0] OPC_LEA    = 8'h8D;
	localparam logic [7:0] OPC_ADD_RR = 8'h01;
	localparam logic [7:0] OPC_SUB_RR = 8'h29;
	localparam logic [7:0] OPC_CMP_RR = 8'h39;
	localparam logic [7:0] OPC_MOV_I  = 8'hC7;
	localparam logic [7:0] OPC_MOV_I64 = 8'hB8;
	localparam logic [7:0] OPC_GRP1_I8 = 8'h83;
	localparam logic [7:0] OPC_GRP1_I32 = 8'h81;
	localparam logic [7:0] OPC_PUSH   = 8'h50;
	localparam logic [7:0] OPC_POP    = 8'h58;
	localparam logic [7:0] OPC_JMP    = 8'hE9;
	localparam logic [7:0] OPC_CALL   = 8'hE8;
	localparam logic [7:0] OPC_ESC    = 8'h0F;
	localparam logic [7:0] OPC_SYSCALL = 8'h05;
	localparam logic [7:0] OPC_RET    = 8'hC3;
	localparam logic [7:0] OPC_NOP    = 8'h90;
	localparam logic [7:0] SIB_RSP    = 8'h24;
	localparam logic [7:0] MODRM_REG  = 8'hC0;

	localparam logic [2:0] EXT_ADD = 3'd0;
	localparam logic [2:0] EXT_SUB = 3'd5;
	localparam logic [2:0] EXT_CMP = 3'd7;

	localparam logic RELOC_PC32  = 1'b0;
	localparam logic RELOC_PLT32 = 1'b1;

	localparam logic [0:0] REG_SIZE_ONLY = 1'b0;

	typedef enum logic [4:0] {
		OP_MOV_RR  = 5'd0,
		OP_MOV_IMM = 5'd1,
		OP_LOAD    = 5'd2,
		OP_STORE   = 5'd3,
		OP_LEA     = 5'd4,
		OP_ADD_RR  = 5'd5,
		OP_SUB_RR  = 5'd6,
		OP_CMP_RR  = 5'd7,
		OP_ADD_IMM = 5'd8,
		OP_SUB_IMM = 5'd9,
		OP_CMP_IMM = 5'd10,
		OP_PUSH    = 5'd11,
		OP_POP     = 5'd12,
		OP_JMP     = 5'd13,
		OP_CALL    = 5'd14,
		OP_JCC     = 5'd15,
		OP_RET     = 5'd16,
		OP_SYSCALL = 5'd17,
		OP_NOP     = 5'd18
	} op_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [3:0]  len;
		logic        info_only;
		logic        err;
		logic        has_rel;
		logic        rel_local;
		logic        rel_kind;
		logic [3:0]  rel_pos;
		logic [31:0] tgt4;
	} desc_t;

	function automatic logic [7:0] jcc_code(input logic [3:0] cond);
		logic [7:0] code;
		if (cond < 4'd8) begin
			code = 8'h82 + {4'd0, cond};
		end else if (cond < 4'd12) begin
			code = 8'h84 + {4'd0, cond};
		end else begin
			code = 8'h8F;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

[hdl/x86_64_instruction_encoder.sv]
// ----------------------------------------------------------------------------
// x86-64 instruction encoder
// Each input transaction names one instruction form; the block returns the
// machine-code bytes, one output transaction per byte, in encoding order.
// The input channel carries the form fields; the output channel carries one
// byte with its length, relocation marks and last flag. Both use valid and
// stall, and a transaction moves when valid is high and stall is low.
// An accepted input is registered in the front-end stage, the queue and the
// emitter's current descriptor; its bytes leave through the output register,
// one byte per cycle while the output is not stalled. An instruction has
// one to ten bytes; in size-only mode or on an encoding error it gives a
// single output transaction. A two-entry descriptor queue lets the front
// end keep accepting while the output is stalled; a stalled output holds
// its transaction. Reset clears the section offset, the size-only register
// and the pipeline and queue control state. size_only is written over the
// APB port at address zero and must only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_64_instruction_encoder import xenc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  op,
	input  wire logic [3:0]  cond,
	input  wire logic [3:0]  reg_a,
	input  wire logic [3:0]  reg_b,
	input  wire logic [3:0]  mem_base,
	input  wire logic        mem_rip,
	input  wire logic        mem_sym,
	input  wire logic signed [63:0] immediate,
	input  wire logic signed [31:0] displacement,
	input  wire logic        target_local,
	input  wire logic [31:0] target_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last,
	output logic [3:0]       instr_length,
	output logic             reloc_here,
	output logic             reloc_kind,
	output logic [31:0]      reloc_offset,
	output logic             error
);

	logic  size_only_q;
	logic  push;
	desc_t push_desc;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	desc_t head_desc;
	logic  reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2:2] == REG_SIZE_ONLY);
	assign prdata  = reg_hit ? {31'd0, size_only_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_only_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			size_only_q <= pwdata[0];
		end
	end

	xenc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.size_only     (size_only_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.cond          (cond),
		.reg_a         (reg_a),
		.reg_b         (reg_b),
		.mem_base      (mem_base),
		.mem_rip       (mem_rip),
		.mem_sym       (mem_sym),
		.immediate     (immediate),
		.displacement  (displacement),
		.target_local  (target_local),
		.target_offset (target_offset),
		.push          (push),
		.push_desc     (push_desc),
		.queue_full    (queue_full)
	);

	xenc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	xenc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.instr_length (instr_length),
		.reloc_here   (reloc_here),
		.reloc_kind   (reloc_kind),
		.reloc_offset (reloc_offset),
		.error        (error)
	);

endmodule

`default_nettype wire

[hdl/xenc_front.sv]
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts one instruction form per transaction, classifies it and builds a
// descriptor with its bytes, length and relocation details.
// ----------------------------------------------------------------------------
`default_nettype none

module xenc_front import xenc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        size_only,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  op,
	input  wire logic [3:0]  cond,
	input  wire logic [3:0]  reg_a,
	input  wire logic [3:0]  reg_b,
	input  wire logic [3:0]  mem_base,
	input  wire logic        mem_rip,
	input  wire logic        mem_sym,
	input  wire logic signed [63:0] immediate,
	input  wire logic signed [31:0] displacement,
	input  wire logic        target_local,
	input  wire logic [31:0] target_offset,
	output logic             push,
	output desc_t            push_desc,
	input  wire logic        queue_full
);

	desc_t      enc;
	desc_t      desc_s1;
	logic       valid_s1;
	logic       accept;
	logic       bad;
	logic [3:0] n;
	logic       imm_fit8;
	logic       imm_fit32;
	logic       disp_fit8;
	logic [1:0] mode;
	logic [2:0] rm;
	logic       rexb;
	logic       sib;
	logic [1:0] dk;
	logic [7:0] opc;
	logic [2:0] ext;

	assign imm_fit8  = (&immediate[63:7]) | ~(|immediate[63:7]);
	assign imm_fit32 = (&immediate[63:31]) | ~(|immediate[63:31]);
	assign disp_fit8 = (&displacement[31:7]) | ~(|displacement[31:7]);

	always_comb begin
		enc = '0;
		n = 4'd0;
		bad = 1'b0;
		mode = 2'd0;
		rm = 3'd5;
		rexb = 1'b0;
		sib = 1'b0;
		dk = 2'd0;
		opc = OPC_MOV_LD;
		ext = EXT_ADD;
		unique case (op_t'(op))
			OP_MOV_RR, OP_ADD_RR, OP_SUB_RR, OP_CMP_RR: begin
				unique case (op_t'(op))
					OP_ADD_RR: opc = OPC_ADD_RR;
					OP_SUB_RR: opc = OPC_SUB_RR;
					OP_CMP_RR: opc = OPC_CMP_RR;
					default:   opc = OPC_MOV_ST;
				endcase
				enc.bytes[0] = REX_W | {5'd0, reg_a[3], 1'b0, reg_b[3]};
				enc.bytes[1] = opc;
				enc.bytes[2] = MODRM_REG | {2'd0, reg_a[2:0], reg_b[2:0]};
				n = 4'd3;
			end
			OP_MOV_IMM: begin
				enc.bytes[0] = REX_W | {7'd0, reg_a[3]};
				if (imm_fit32) begin
					enc.bytes[1] = OPC_MOV_I;
					enc.bytes[2] = MODRM_REG | {5'd0, reg_a[2:0]};
					for (int i = 0; i < 4; i++) begin
						enc.bytes[3 + i] = immediate[8*i +: 8];
					end
					n = 4'd7;
				end else begin
					enc.bytes[1] = OPC_MOV_I64 | {5'd0, reg_a[2:0]};
					for (int i = 0; i < 8; i++) begin
						enc.bytes[2 + i] = immediate[8*i +: 8];
					end
					n = 4'd10;
				end
			end
			OP_LOAD, OP_STORE, OP_LEA: begin
				unique case (op_t'(op))
					OP_STORE: opc = OPC_MOV_ST;
					OP_LEA:   opc = OPC_LEA;
					default:  opc = OPC_MOV_LD;
				endcase
				if (mem_rip) begin
					dk = mem_sym ? 2'd3 : 2'd2;
				end else begin
					rexb = mem_base[3];
					rm = mem_base[2:0];
					sib = (mem_base[2:0] == 3'd4);
					if (displacement == 32'sd0 && mem_base[2:0] != 3'd5) begin
						mode = 2'd0;
						dk = 2'd0;
					end else if (disp_fit8) begin
						mode = 2'd1;
						dk = 2'd1;
					end else begin
						mode = 2'd2;
						dk = 2'd2;
					end
				end
				enc.bytes[0] = REX_W | {5'd0, reg_a[3], 1'b0, rexb};
				enc.bytes[1] = opc;
				enc.bytes[2] = {mode, reg_a[2:0], rm};
				n = 4'd3;
				if (sib) begin
					enc.bytes[3] = SIB_RSP;
					n = 4'd4;
				end
				unique case (dk)
					2'd1: begin
						enc.bytes[n] = displacement[7:0];
						n = n + 4'd1;
					end
					2'd2: begin
						for (int i = 0; i < 4; i++) begin
							enc.bytes[n + 4'(i)] = displacement[8*i +: 8];
						end
						n = n + 4'd4;
					end
					2'd3: begin
						enc.has_rel = 1'b1;
						enc.rel_local = target_local;
						enc.rel_kind = RELOC_PC32;
						enc.rel_pos = n;
						n = n + 4'd4;
					end
					default: begin
					end
				endcase
			end
			OP_ADD_IMM, OP_SUB_IMM, OP_CMP_IMM: begin
				unique case (op_t'(op))
					OP_SUB_IMM: ext = EXT_SUB;
					OP_CMP_IMM: ext = EXT_CMP;
					default:    ext = EXT_ADD;
				endcase
				if (!imm_fit32) begin
					bad = 1'b1;
				end else begin
					enc.bytes[0] = REX_W | {7'd0, reg_a[3]};
					enc.bytes[1] = imm_fit8 ? OPC_GRP1_I8 : OPC_GRP1_I32;
					enc.bytes[2] = MODRM_REG | {2'd0, ext, reg_a[2:0]};
					if (imm_fit8) begin
						enc.bytes[3] = immediate[7:0];
						n = 4'd4;
					end else begin
						for (int i = 0; i < 4; i++) begin
							enc.bytes[3 + i] = immediate[8*i +: 8];
						end
						n = 4'd7;
					end
				end
			end
			OP_PUSH, OP_POP: begin
				if (reg_a[3]) begin
					enc.bytes[0] = REX_B_ONLY;
					n = 4'd1;
				end
				enc.bytes[n] = ((op_t'(op) == OP_PUSH) ? OPC_PUSH : OPC_POP) |
					{5'd0, reg_a[2:0]};
				n = n + 4'd1;
			end
			OP_JMP, OP_CALL: begin
				enc.bytes[0] = (op_t'(op) == OP_JMP) ? OPC_JMP : OPC_CALL;
				enc.has_rel = 1'b1;
				enc.rel_local = target_local;
				enc.rel_kind = RELOC_PLT32;
				enc.rel_pos = 4'd1;
				n = 4'd5;
			end
			OP_JCC: begin
				enc.bytes[0] = OPC_ESC;
				enc.bytes[1] = jcc_code(cond);
				enc.has_rel = 1'b1;
				enc.rel_local = target_local;
				enc.rel_kind = RELOC_PLT32;
				enc.rel_pos = 4'd2;
				n = 4'd6;
			end
			OP_RET: begin
				enc.bytes[0] = OPC_RET;
				n = 4'd1;
			end
			OP_SYSCALL: begin
				enc.bytes[0] = OPC_ESC;
				enc.bytes[1] = OPC_SYSCALL;
				n = 4'd2;
			end
			OP_NOP: begin
				enc.bytes[0] = OPC_NOP;
				n = 4'd1;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
		enc.err = bad;
		enc.info_only = size_only | bad;
		enc.len = bad ? 4'd0 : n;
		enc.tgt4 = target_offset - 32'd4;
	end

	assign in_stall  = valid_s1 & queue_full;
	assign accept    = in_valid & ~in_stall;
	assign push      = valid_s1 & ~queue_full;
	assign push_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= enc;
		end
	end

endmodule

`default_nettype wire

[hdl/xenc_queue.sv]
// ----------------------------------------------------------------------------
// Descriptor queue
// Short first-in first-out buffer that decouples the front end from the
// byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module xenc_queue import xenc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output desc_t      head_desc
);

	desc_t                 entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_pop;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

[hdl/xenc_back.sv]
// ----------------------------------------------------------------------------
// Byte emitter
// Walks the current descriptor one byte per cycle unless stalled, resolves
// local rel32 fields against the running offset, drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xenc_back import xenc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire desc_t  head_desc,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic [3:0]  instr_length,
	output logic        reloc_here,
	output logic        reloc_kind,
	output logic [31:0] reloc_offset,
	output logic        error
);

	desc_t                   cur_q;
	logic                    cur_valid_q;
	logic [3:0]              idx_q;
	logic [OFFSET_WIDTH-1:0] run_q;
	logic [3:0][7:0]         rel_q;
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    byte_valid_q;
	logic                    last_q;
	logic [3:0]              len_q;
	logic                    reloc_here_q;
	logic                    reloc_kind_q;
	logic [31:0]             reloc_offset_q;
	logic                    error_q;

	logic            emit;
	logic            is_last;
	logic            load;
	logic [31:0]     run32;
	logic [3:0][7:0] diff;
	logic [3:0]      rel_off;
	logic            in_rel;
	logic            at_reloc;
	logic [7:0]      sel_byte;

	assign emit    = cur_valid_q & (~out_valid_q | ~out_stall);
	assign is_last = cur_q.info_only | (idx_q == cur_q.len - 4'd1);
	assign load    = head_valid & (~cur_valid_q | (emit & is_last));
	assign pop     = load;

	assign run32    = 32'(run_q);
	assign diff     = cur_q.tgt4 - run32;
	assign rel_off  = idx_q - cur_q.rel_pos;
	assign in_rel   = cur_q.has_rel & cur_q.rel_local & (idx_q >= cur_q.rel_pos) &
		(rel_off < 4'd4);
	assign at_reloc = cur_q.has_rel & ~cur_q.rel_local & (idx_q == cur_q.rel_pos);

	always_comb begin
		if (in_rel) begin
			sel_byte = (rel_off == 4'd0) ? diff[0] : rel_q[rel_off[1:0]];
		end else begin
			sel_byte = cur_q.bytes[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 4'd1;
			end
			if (emit && !cur_q.info_only) begin
				run_q <= run_q + OFFSET_WIDTH'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head_desc;
		end
		if (emit && in_rel && rel_off == 4'd0) begin
			rel_q <= diff;
		end
		if (emit) begin
			len_q <= cur_q.len;
			if (cur_q.info_only) begin
				out_byte_q     <= 8'd0;
				byte_valid_q   <= 1'b0;
				last_q         <= 1'b1;
				reloc_here_q   <= 1'b0;
				reloc_kind_q   <= 1'b0;
				reloc_offset_q <= 32'd0;
				error_q        <= cur_q.err;
			end else begin
				out_byte_q     <= sel_byte;
				byte_valid_q   <= 1'b1;
				last_q         <= is_last;
				reloc_here_q   <= at_reloc;
				reloc_kind_q   <= at_reloc ? cur_q.rel_kind : 1'b0;
				reloc_offset_q <= at_reloc ? run32 : 32'd0;
				error_q        <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign last         = last_q;
	assign instr_length = len_q;
	assign reloc_here   = reloc_here_q;
	assign reloc_kind   = reloc_kind_q;
	assign reloc_offset = reloc_offset_q;
	assign error        = error_q;

endmodule

`default_nettype wire

[dv/xenc_byte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream checker for the x86-64 instruction encoder
// Watches the configuration port and both channels. Every accepted input
// transaction is encoded here into the byte transactions the block has to
// return, and every accepted output transaction is compared field by field
// with the oldest of them. The number of failures and the number of
// output transactions still owed are handed to the testbench top.
// ----------------------------------------------------------------------------

module xenc_byte_checker import xenc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [4:0]          op,
	input  logic [3:0]          cond,
	input  logic [3:0]          reg_a,
	input  logic [3:0]          reg_b,
	input  logic [3:0]          mem_base,
	input  logic                mem_rip,
	input  logic                mem_sym,
	input  logic signed [63:0]  immediate,
	input  logic signed [31:0]  displacement,
	input  logic                target_local,
	input  logic [31:0]         target_offset,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [7:0]          out_byte,
	input  logic                byte_valid,
	input  logic                last,
	input  logic [3:0]          instr_length,
	input  logic                reloc_here,
	input  logic                reloc_kind,
	input  logic [31:0]         reloc_offset,
	input  logic                error,
	output int                  pending,
	output int                  fail_count
);

	localparam logic [2:0] ADDR_SIZE_ONLY = {REG_SIZE_ONLY, 2'b00};

	typedef enum logic [1:0] {DISP_NONE, DISP_8, DISP_32, DISP_REL} disp_kind_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        has_byte;
		logic        is_last;
		logic [3:0]  length;
		logic        reloc_at;
		logic        kind;
		logic [31:0] reloc_off;
		logic        err;
	} byte_rec_t;

	byte_rec_t expected_bytes[$];
	byte_rec_t got;
	byte_rec_t want;

	logic [OFFSET_WIDTH-1:0] section_off = '0;
	logic                    size_only_q = 1'b0;
	logic [7:0]              enc_buf [MAX_BYTES];
	int                      enc_len;
	int                      rel_at;
	logic                    rel_kind_q;
	int                      mismatches = 0;

	function automatic logic fits_s8(input logic [63:0] v);
		return v == {{56{v[7]}}, v[7:0]};
	endfunction

	function automatic logic fits_imm32(input logic [63:0] v);
		return v == {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		if (enc_len < MAX_BYTES) begin
			enc_buf[enc_len] = b;
			enc_len++;
		end
	endfunction

	function automatic void put_word(input logic [31:0] w);
		int i;
		for (i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
	endfunction

	// A rel32 field against a local label is resolved from the end of the field;
	// anything else is left as zero and marked for the linker.
	function automatic void put_rel(input logic kind);
		logic [OFFSET_WIDTH-1:0] field_at;
		logic [31:0]             rel;
		field_at = section_off + enc_len;
		if (target_local) begin
			rel = target_offset - field_at - 32'd4;
			put_word(rel);
		end else begin
			rel_at = enc_len;
			rel_kind_q = kind;
			put_word(32'd0);
		end
	endfunction

	function automatic void put_rr(input logic [7:0] opc, input logic [3:0] src,
			input logic [3:0] dst);
		put_byte(REX_W | {5'd0, src[3], 1'b0, dst[3]});
		put_byte(opc);
		put_byte(MODRM_REG | {2'd0, src[2:0], dst[2:0]});
	endfunction

	function automatic void put_mem(input logic [7:0] opc);
		logic [1:0]         md;
		logic [2:0]         rm;
		logic               rex_b;
		logic               need_sib;
		logic signed [31:0] disp;
		disp_kind_t         dk;
		md = 2'd0;
		rm = 3'd5;
		rex_b = 1'b0;
		need_sib = 1'b0;
		disp = displacement;
		dk = DISP_NONE;
		if (mem_rip) begin
			dk = mem_sym ? DISP_REL : DISP_32;
		end else begin
			rex_b = mem_base[3];
			rm = mem_base[2:0];
			need_sib = (mem_base[2:0] == 3'd4);
			if (disp == 0 && mem_base[2:0] != 3'd5) begin
				md = 2'd0;
				dk = DISP_NONE;
			end else if (fits_s8({{32{disp[31]}}, disp})) begin
				md = 2'd1;
				dk = DISP_8;
			end else begin
				md = 2'd2;
				dk = DISP_32;
			end
		end
		put_byte(REX_W | {5'd0, reg_a[3], 1'b0, rex_b});
		put_byte(opc);
		put_byte({md, reg_a[2:0], rm});
		if (need_sib) put_byte(SIB_RSP);
		case (dk)
			DISP_8: put_byte(disp[7:0]);
			DISP_32: put_word(disp);
			DISP_REL: put_rel(RELOC_PC32);
			default: ;
		endcase
	endfunction

	function automatic logic put_grp1(input logic [2:0] ext, input logic [3:0] dst,
			input logic [63:0] v);
		if (!fits_imm32(v)) return 1'b0;
		put_byte(REX_W | {7'd0, dst[3]});
		put_byte(fits_s8(v) ? OPC_GRP1_I8 : OPC_GRP1_I32);
		put_byte(MODRM_REG | {2'd0, ext, dst[2:0]});
		if (fits_s8(v)) put_byte(v[7:0]);
		else put_word(v[31:0]);
		return 1'b1;
	endfunction

	// Conditions above the last defined one saturate to the last opcode.
	function automatic logic [7:0] jcc_byte(input logic [3:0] c);
		if (c < 4'd6) return 8'h82 + c;
		if (c < 4'd8) return 8'h88 + (c - 4'd6);
		if (c < 4'd12) return 8'h8C + (c - 4'd8);
		return 8'h8F;
	endfunction

	function automatic void encode_instr();
		logic [63:0] imm;
		logic        enc_err;
		byte_rec_t   rec;
		int          k;
		imm = immediate;
		enc_len = 0;
		rel_at = -1;
		rel_kind_q = RELOC_PC32;
		enc_err = 1'b0;
		case (op)
			OP_MOV_RR: put_rr(OPC_MOV_ST, reg_a, reg_b);
			OP_MOV_IMM: begin
				put_byte(REX_W | {7'd0, reg_a[3]});
				if (fits_imm32(imm)) begin
					put_byte(OPC_MOV_I);
					put_byte(MODRM_REG | {5'd0, reg_a[2:0]});
					put_word(imm[31:0]);
				end else begin
					put_byte(OPC_MOV_I64 | {5'd0, reg_a[2:0]});
					put_word(imm[31:0]);
					put_word(imm[63:32]);
				end
			end
			OP_LOAD: put_mem(OPC_MOV_LD);
			OP_STORE: put_mem(OPC_MOV_ST);
			OP_LEA: put_mem(OPC_LEA);
			OP_ADD_RR: put_rr(OPC_ADD_RR, reg_a, reg_b);
			OP_SUB_RR: put_rr(OPC_SUB_RR, reg_a, reg_b);
			OP_CMP_RR: put_rr(OPC_CMP_RR, reg_a, reg_b);
			OP_ADD_IMM: enc_err = !put_grp1(EXT_ADD, reg_a, imm);
			OP_SUB_IMM: enc_err = !put_grp1(EXT_SUB, reg_a, imm);
			OP_CMP_IMM: enc_err = !put_grp1(EXT_CMP, reg_a, imm);
			OP_PUSH, OP_POP: begin
				if (reg_a[3]) put_byte(REX_B_ONLY);
				put_byte(((op == OP_PUSH) ? OPC_PUSH : OPC_POP) | {5'd0, reg_a[2:0]});
			end
			OP_JMP: begin
				put_byte(OPC_JMP);
				put_rel(RELOC_PLT32);
			end
			OP_CALL: begin
				put_byte(OPC_CALL);
				put_rel(RELOC_PLT32);
			end
			OP_JCC: begin
				put_byte(OPC_ESC);
				put_byte(jcc_byte(cond));
				put_rel(RELOC_PLT32);
			end
			OP_RET: put_byte(OPC_RET);
			OP_SYSCALL: begin
				put_byte(OPC_ESC);
				put_byte(OPC_SYSCALL);
			end
			OP_NOP: put_byte(OPC_NOP);
			default: enc_err = 1'b1;
		endcase

		if (size_only_q || enc_err) begin
			rec = '0;
			rec.is_last = 1'b1;
			rec.length = enc_err ? 4'd0 : 4'(enc_len);
			rec.err = enc_err;
			expected_bytes.push_back(rec);
		end else begin
			for (k = 0; k < enc_len; k++) begin
				rec = '0;
				rec.data = enc_buf[k];
				rec.has_byte = 1'b1;
				rec.is_last = (k == enc_len - 1);
				rec.length = 4'(enc_len);
				if (k == rel_at) begin
					rec.reloc_at = 1'b1;
					rec.kind = rel_kind_q;
					rec.reloc_off = section_off + k;
				end
				expected_bytes.push_back(rec);
			end
			section_off = section_off + enc_len;
		end
	endfunction

	function automatic string format_rec(input byte_rec_t r);
		return $sformatf("byte=%02h bv=%0b last=%0b len=%0d reloc=%0b kind=%0b roff=%08h err=%0b",
			r.data, r.has_byte, r.is_last, r.length, r.reloc_at, r.kind, r.reloc_off, r.err);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			section_off = '0;
			size_only_q = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SIZE_ONLY)
				size_only_q = pwdata[0];
			if (out_valid && !out_stall) begin
				got.data = out_byte;
				got.has_byte = byte_valid;
				got.is_last = last;
				got.length = instr_length;
				got.reloc_at = reloc_here;
				got.kind = reloc_kind;
				got.reloc_off = reloc_offset;
				got.err = error;
				if (expected_bytes.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: output transaction with nothing expected: %s",
							$realtime, format_rec(got));
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch, expected %s", $realtime, format_rec(want));
							$display("%0t:           actual   %s", $realtime, format_rec(got));
						end
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) encode_instr();
		end
		pending <= expected_bytes.size();
		fail_count <= mismatches;
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the x86-64 instruction encoder
// Sends a directed set of instruction forms followed by random ones in
// bursts with random gaps, while the output side stalls in changing
// patterns. The size-only register is switched between phases while the
// block is idle. A separate checker predicts and compares every byte.
// ----------------------------------------------------------------------------

module tb import xenc_pkg::*; ();

	localparam logic [2:0] ADDR_SIZE_ONLY = {REG_SIZE_ONLY, 2'b00};
	localparam logic [4:0] OP_UNDEF_FIRST = 5'd19;
	localparam logic [4:0] OP_UNDEF_LAST  = 5'd31;
	localparam int         TAIL_CYCLES    = 30;
	localparam int         TIMEOUT_NS     = 4_000_000;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [3:0]  cond;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [3:0]  mem_base;
		logic        mem_rip;
		logic        mem_sym;
		logic [63:0] immediate;
		logic [31:0] displacement;
		logic        target_local;
		logic [31:0] target_offset;
	} instr_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [4:0]         op = '0;
	logic [3:0]         cond = '0;
	logic [3:0]         reg_a = '0;
	logic [3:0]         reg_b = '0;
	logic [3:0]         mem_base = '0;
	logic               mem_rip = 1'b0;
	logic               mem_sym = 1'b0;
	logic signed [63:0] immediate = '0;
	logic signed [31:0] displacement = '0;
	logic               target_local = 1'b0;
	logic [31:0]        target_offset = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               byte_valid;
	logic               last;
	logic [3:0]         instr_length;
	logic               reloc_here;
	logic               reloc_kind;
	logic [31:0]        reloc_offset;
	logic               error;
	int                 pending;
	int                 fail_count;

	stall_mode_t        stall_mode = STALL_NONE;
	int                 stall_left = 0;
	instr_t             stim_q[$];

	x86_64_instruction_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .cond(cond), .reg_a(reg_a), .reg_b(reg_b), .mem_base(mem_base),
		.mem_rip(mem_rip), .mem_sym(mem_sym), .immediate(immediate),
		.displacement(displacement), .target_local(target_local),
		.target_offset(target_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .byte_valid(byte_valid), .last(last),
		.instr_length(instr_length), .reloc_here(reloc_here), .reloc_kind(reloc_kind),
		.reloc_offset(reloc_offset), .error(error)
	);

	xenc_byte_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .cond(cond), .reg_a(reg_a), .reg_b(reg_b), .mem_base(mem_base),
		.mem_rip(mem_rip), .mem_sym(mem_sym), .immediate(immediate),
		.displacement(displacement), .target_local(target_local),
		.target_offset(target_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .byte_valid(byte_valid), .last(last),
		.instr_length(instr_length), .reloc_here(reloc_here), .reloc_kind(reloc_kind),
		.reloc_offset(reloc_offset), .error(error),
		.pending(pending), .fail_count(fail_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The output side switches between stall patterns, each held for a random stretch.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ~out_stall;
		endcase
	end

	function automatic logic [63:0] rand_imm();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0, 1: v = {{56{v[7]}}, v[7:0]};
			2: v = {{32{v[31]}}, v[31:0]};
			3: begin
				case ($urandom_range(0, 7))
					0: v = 64'd127;
					1: v = 64'd128;
					2: v = 64'hFFFF_FFFF_FFFF_FF80;
					3: v = 64'hFFFF_FFFF_FFFF_FF7F;
					4: v = 64'h0000_0000_7FFF_FFFF;
					5: v = 64'h0000_0000_8000_0000;
					6: v = 64'hFFFF_FFFF_8000_0000;
					default: v = 64'hFFFF_FFFF_7FFF_FFFF;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_disp();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 4))
			0: v = 32'd0;
			1: v = {{24{v[7]}}, v[7:0]};
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'd127;
					1: v = 32'd128;
					2: v = 32'hFFFF_FF80;
					default: v = 32'hFFFF_FF7F;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic instr_t rand_instr();
		instr_t it;
		if ($urandom_range(0, 24) == 0)
			it.op = 5'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
		else it.op = 5'($urandom_range(OP_MOV_RR, OP_NOP));
		it.cond = 4'($urandom_range(0, 15));
		it.reg_a = 4'($urandom_range(0, 15));
		it.reg_b = 4'($urandom_range(0, 15));
		it.mem_base = 4'($urandom_range(0, 15));
		it.mem_rip = ($urandom_range(0, 3) == 0);
		it.mem_sym = 1'($urandom_range(0, 1));
		it.immediate = rand_imm();
		it.displacement = rand_disp();
		it.target_local = 1'($urandom_range(0, 1));
		it.target_offset = $urandom;
		return it;
	endfunction

	function automatic instr_t mk(input logic [4:0] o, input logic [3:0] c, input logic [3:0] a,
			input logic [3:0] b, input logic [3:0] base, input logic rip, input logic sym,
			input logic [63:0] imm, input logic [31:0] disp, input logic loc,
			input logic [31:0] tgt);
		instr_t it;
		it.op = o;
		it.cond = c;
		it.reg_a = a;
		it.reg_b = b;
		it.mem_base = base;
		it.mem_rip = rip;
		it.mem_sym = sym;
		it.immediate = imm;
		it.displacement = disp;
		it.target_local = loc;
		it.target_offset = tgt;
		return it;
	endfunction

	task automatic add_random(input int n);
		int i;
		for (i = 0; i < n; i++) stim_q.push_back(rand_instr());
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_instr(input instr_t it);
		op <= it.op;
		cond <= it.cond;
		reg_a <= it.reg_a;
		reg_b <= it.reg_b;
		mem_base <= it.mem_base;
		mem_rip <= it.mem_rip;
		mem_sym <= it.mem_sym;
		immediate <= it.immediate;
		displacement <= it.displacement;
		target_local <= it.target_local;
		target_offset <= it.target_offset;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic run_stimulus();
		int burst_left;
		int gap;
		burst_left = 0;
		while (stim_q.size() != 0) begin
			if (burst_left == 0)
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
			send_instr(stim_q.pop_front());
			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_write(ADDR_SIZE_ONLY, 32'd0);

		stim_q.push_back(mk(OP_MOV_RR, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_MOV_IMM, 0, 8, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0));
		stim_q.push_back(mk(OP_MOV_IMM, 0, 7, 0, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0));
		stim_q.push_back(mk(OP_MOV_IMM, 0, 0, 0, 0, 0, 0, 64'h0000_0000_8000_0000, 0, 0, 0));
		stim_q.push_back(mk(OP_MOV_IMM, 0, 15, 0, 0, 0, 0, '1, 0, 0, 0));
		stim_q.push_back(mk(OP_LOAD, 0, 0, 0, 4, 0, 0, 0, 32'd0, 0, 0));
		stim_q.push_back(mk(OP_STORE, 0, 9, 0, 12, 0, 0, 0, 32'd128, 0, 0));
		stim_q.push_back(mk(OP_LEA, 0, 15, 0, 13, 0, 0, 0, 32'd0, 0, 0));
		stim_q.push_back(mk(OP_LOAD, 0, 2, 0, 5, 0, 0, 0, 32'hFFFF_FF80, 0, 0));
		stim_q.push_back(mk(OP_STORE, 0, 1, 0, 3, 0, 0, 0, 32'd127, 0, 0));
		stim_q.push_back(mk(OP_LEA, 0, 4, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
		stim_q.push_back(mk(OP_LOAD, 0, 6, 0, 7, 1, 0, 0, 32'h7FFF_FFFF, 0, 0));
		stim_q.push_back(mk(OP_LEA, 0, 12, 0, 4, 1, 1, 0, 32'h1234_5678, 0, 0));
		stim_q.push_back(mk(OP_STORE, 0, 5, 0, 9, 1, 1, 0, 0, 1, 32'h0000_0010));
		stim_q.push_back(mk(OP_ADD_IMM, 0, 0, 0, 0, 0, 0, 64'd127, 0, 0, 0));
		stim_q.push_back(mk(OP_SUB_IMM, 0, 15, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FF7F, 0, 0, 0));
		stim_q.push_back(mk(OP_CMP_IMM, 0, 9, 0, 0, 0, 0, 64'h0000_0000_8000_0000, 0, 0, 0));
		stim_q.push_back(mk(OP_ADD_RR, 0, 0, 15, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_SUB_RR, 0, 11, 3, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_CMP_RR, 0, 6, 12, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_PUSH, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_JMP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd0));
		stim_q.push_back(mk(OP_CALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF));
		stim_q.push_back(mk(OP_JCC, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_JCC, 15, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF));
		stim_q.push_back(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_SYSCALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_UNDEF_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_random(100);
		run_stimulus();
		wait_drained();

		cfg_write(ADDR_SIZE_ONLY, 32'd1);
		add_random(40);
		run_stimulus();
		wait_drained();

		cfg_write(ADDR_SIZE_ONLY, 32'd0);
		add_random(65);
		run_stimulus();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[x86_64_instruction_encoder.f]
hdl/xenc_pkg.sv
hdl/xenc_front.sv
hdl/xenc_queue.sv
hdl/xenc_back.sv
hdl/x86_64_instruction_encoder.sv
dv/xenc_byte_checker.sv
dv/tb.sv
